@@ rtl/core/streaming_fir_convolver_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef STREAMING_FIR_CONVOLVER_MACROS_SVH
`define STREAMING_FIR_CONVOLVER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SFC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define SFC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sfc_pkg.sv @@
`default_nettype none
package sfc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam int unsigned TAP_INDEX_WIDTH = 6;
  localparam int unsigned NUM_TAPS_WIDTH  = 7;

  // Controls from the sequencer to the serial multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic load;
    logic sample_ok;
    logic step;
    logic round;
  } mac_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/streaming_fir_convolver.sv @@
// Channel   Direction  Handshake            Payload
// s_axis    in         s_tvalid / s_tready  tuser cmd; tdata tap_index, tap_value, sample_in
// m_axis    out        m_tvalid / m_tready  tdata sample_out; tuser clipped; tlast last
// cfg       in         cfg_valid/cfg_ready  cfg_data num_taps
//
// Each result is built tap by tap for the n taps in use: per tap one memory
// read, one operand load and SAMPLE_WIDTH steps of the bit-serial multiplier.
// A sample item keeps the block busy until its result is registered; a load item does not.
// A flush item yields n-1 results, one after another, each built the same way.
// Reset is synchronous; the delay line is emptied through a fill count, without a pass.
// A stalled output holds the finished result while the next one is computed.
`default_nettype none
module streaming_fir_convolver #(
  parameter int unsigned MAX_TAPS     = 64,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 18
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // tap_index [5:0], tap_value, sample_in, zero fill to whole bytes
  input  wire logic [((sfc_pkg::TAP_INDEX_WIDTH+COEF_WIDTH+SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  // cmd
  input  wire logic [1:0] s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // sample_out, zero fill to whole bytes
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  // clipped
  output logic      m_tuser,
  output logic      m_tlast,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [sfc_pkg::NUM_TAPS_WIDTH-1:0] cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_TAPS);
  localparam int unsigned TIW = sfc_pkg::TAP_INDEX_WIDTH;
  localparam int unsigned IW  = ((AW > TIW) ? AW : TIW) + 1;
  localparam int unsigned NTW = sfc_pkg::NUM_TAPS_WIDTH;
  localparam int unsigned CW  = ((AW + 1) > NTW) ? (AW + 1) : NTW;
  localparam int unsigned OW  = ((SAMPLE_WIDTH + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_OPLOAD,
    ST_MUL,
    ST_ROUND,
    ST_OUT
  } state_t;

  state_t                 state;
  logic [NTW-1:0]         num_taps;
  logic [AW:0]            fill;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          rd;
  logic [AW:0]            k;
  logic [AW-1:0]          tail;
  logic                   is_flush;

  logic [AW:0]            n_eff;
  logic [CW-1:0]          nt_ext;
  logic [AW-1:0]          wp_inc;
  logic [AW:0]            fill_inc;
  logic [IW-1:0]          ti_ext;
  logic                   accept;
  sfc_pkg::cmd_t          cmd;
  logic                   out_free;

  logic [TIW-1:0]          f_tap_index;
  logic [COEF_WIDTH-1:0]   f_tap_value;
  logic [SAMPLE_WIDTH-1:0] f_sample_in;

  logic                    coef_we;
  logic                    dly_we;
  logic [SAMPLE_WIDTH-1:0] dly_wdata;
  logic [COEF_WIDTH-1:0]   coef_rdata;
  logic [SAMPLE_WIDTH-1:0] dly_rdata;

  sfc_pkg::mac_ctrl_t      mac_ctrl;
  logic                    last_bit;
  logic [SAMPLE_WIDTH-1:0] mac_result;
  logic                    mac_clip;

  assign f_tap_index = s_tdata[TIW-1:0];
  assign f_tap_value = s_tdata[TIW+COEF_WIDTH-1:TIW];
  assign f_sample_in = s_tdata[TIW+COEF_WIDTH+SAMPLE_WIDTH-1:TIW+COEF_WIDTH];
  assign cmd         = sfc_pkg::cmd_t'(s_tuser);

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    nt_ext = CW'(num_taps);
    if (nt_ext == '0) begin
      n_eff = (AW+1)'(1);
    end else if (nt_ext > CW'(MAX_TAPS)) begin
      n_eff = (AW+1)'(MAX_TAPS);
    end else begin
      n_eff = nt_ext[AW:0];
    end
  end

  assign wp_inc   = (wp == AW'(MAX_TAPS - 1)) ? '0 : wp + AW'(1);
  assign fill_inc = (fill == (AW+1)'(MAX_TAPS)) ? fill : fill + (AW+1)'(1);
  assign ti_ext   = IW'(f_tap_index);

  // A shift happens on an accepted sample, on an accepted flush with a tail,
  // and before every further tail result of a flush.
  always_comb begin
    coef_we   = 1'b0;
    dly_we    = 1'b0;
    dly_wdata = '0;
    if (accept) begin
      unique case (cmd)
        sfc_pkg::CMD_LOAD: coef_we = (ti_ext < IW'(MAX_TAPS));
        sfc_pkg::CMD_SAMPLE: begin
          dly_we    = 1'b1;
          dly_wdata = f_sample_in;
        end
        sfc_pkg::CMD_FLUSH: dly_we = (n_eff != (AW+1)'(1));
        default: dly_we = 1'b0;
      endcase
    end else if (state == ST_OUT && out_free && is_flush && tail != AW'(1)) begin
      dly_we = 1'b1;
    end
  end

  always_comb begin
    mac_ctrl           = '0;
    mac_ctrl.clear     = (state == ST_READ) && (k == '0);
    mac_ctrl.load      = (state == ST_OPLOAD);
    mac_ctrl.sample_ok = (k < fill);
    mac_ctrl.step      = (state == ST_MUL);
    mac_ctrl.round     = (state == ST_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      num_taps <= NTW'(1);
      fill     <= '0;
      wp       <= '0;
      rd       <= '0;
      k        <= '0;
      tail     <= '0;
      is_flush <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_taps <= cfg_data;
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == sfc_pkg::CMD_SAMPLE) begin
              wp       <= wp_inc;
              rd       <= wp_inc;
              fill     <= fill_inc;
              k        <= '0;
              is_flush <= 1'b0;
              state    <= ST_READ;
            end else if (cmd == sfc_pkg::CMD_FLUSH) begin
              if (n_eff == (AW+1)'(1)) begin
                fill <= '0;
              end else begin
                wp       <= wp_inc;
                rd       <= wp_inc;
                fill     <= fill_inc;
                k        <= '0;
                tail     <= AW'(n_eff - (AW+1)'(1));
                is_flush <= 1'b1;
                state    <= ST_READ;
              end
            end
          end
        end
        ST_READ: state <= ST_OPLOAD;
        ST_OPLOAD: state <= ST_MUL;
        ST_MUL: begin
          if (last_bit) begin
            k     <= k + (AW+1)'(1);
            rd    <= (rd == '0) ? AW'(MAX_TAPS - 1) : rd - AW'(1);
            state <= (k + (AW+1)'(1) == n_eff) ? ST_ROUND : ST_READ;
          end
        end
        ST_ROUND: state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            if (is_flush && tail != AW'(1)) begin
              tail  <= tail - AW'(1);
              wp    <= wp_inc;
              rd    <= wp_inc;
              fill  <= fill_inc;
              k     <= '0;
              state <= ST_READ;
            end else begin
              if (is_flush) begin
                fill <= '0;
              end
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= OW'(mac_result);
      m_tuser <= mac_clip;
      m_tlast <= is_flush && (tail == AW'(1));
    end
  end

  sfc_store #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .AW          (AW)
  ) u_store (
    .clk       (clk),
    .coef_we   (coef_we),
    .coef_waddr(AW'(ti_ext)),
    .coef_wdata(f_tap_value),
    .coef_raddr(k[AW-1:0]),
    .coef_rdata(coef_rdata),
    .dly_we    (dly_we),
    .dly_waddr (wp_inc),
    .dly_wdata (dly_wdata),
    .dly_raddr (rd),
    .dly_rdata (dly_rdata)
  );

  sfc_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .AW          (AW)
  ) u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .coef    (coef_rdata),
    .sample  (dly_rdata),
    .last_bit(last_bit),
    .result  (mac_result),
    .clip    (mac_clip)
  );

endmodule
`default_nettype wire

@@ rtl/core/sfc_store.sv @@
`default_nettype none
module sfc_store #(
  parameter int unsigned MAX_TAPS     = 64,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 18,
  parameter int unsigned AW           = 6
) (
  input  wire logic                    clk,
  input  wire logic                    coef_we,
  input  wire logic [AW-1:0]           coef_waddr,
  input  wire logic [COEF_WIDTH-1:0]   coef_wdata,
  input  wire logic [AW-1:0]           coef_raddr,
  output logic      [COEF_WIDTH-1:0]   coef_rdata,
  input  wire logic                    dly_we,
  input  wire logic [AW-1:0]           dly_waddr,
  input  wire logic [SAMPLE_WIDTH-1:0] dly_wdata,
  input  wire logic [AW-1:0]           dly_raddr,
  output logic      [SAMPLE_WIDTH-1:0] dly_rdata
);

  logic [COEF_WIDTH-1:0]   coef_mem [MAX_TAPS];
  logic [SAMPLE_WIDTH-1:0] dly_mem  [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_waddr] <= dly_wdata;
    end
    dly_rdata <= dly_mem[dly_raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/sfc_mac.sv @@
`default_nettype none
module sfc_mac #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 18,
  parameter int unsigned AW           = 6
) (
  input  wire logic                    clk,
  input  wire sfc_pkg::mac_ctrl_t      ctrl,
  input  wire logic [COEF_WIDTH-1:0]   coef,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  output logic                         last_bit,
  output logic      [SAMPLE_WIDTH-1:0] result,
  output logic                         clip
);

  localparam int unsigned ACC_W = SAMPLE_WIDTH + COEF_WIDTH + AW + 1;
  localparam int unsigned BCW   = $clog2(SAMPLE_WIDTH);

  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        mcand;
  logic [SAMPLE_WIDTH-1:0] mplier;
  logic [BCW-1:0]          bit_cnt;
  logic [ACC_W-1:0]        addend;
  logic signed [ACC_W-1:0] q;
  logic signed [ACC_W-1:0] hi;
  logic signed [ACC_W-1:0] lo;

  assign last_bit = (bit_cnt == BCW'(SAMPLE_WIDTH - 1));

  // The sample's top bit carries negative weight, so its partial product is subtracted.
  always_comb begin
    addend = '0;
    if (mplier[0]) begin
      addend = last_bit ? (~mcand + ACC_W'(1)) : mcand;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.step) begin
      acc <= acc + addend;
    end else if (ctrl.round) begin
      acc <= acc + (ACC_W'(1) << (COEF_WIDTH - 2));
    end
    if (ctrl.load) begin
      mcand   <= {{(ACC_W-COEF_WIDTH){coef[COEF_WIDTH-1]}}, coef};
      mplier  <= ctrl.sample_ok ? sample : '0;
      bit_cnt <= '0;
    end else if (ctrl.step) begin
      mcand   <= mcand << 1;
      mplier  <= mplier >> 1;
      bit_cnt <= bit_cnt + BCW'(1);
    end
  end

  assign q  = $signed(acc) >>> (COEF_WIDTH - 1);
  assign hi = $signed({{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
  assign lo = $signed({{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}});

  always_comb begin
    result = q[SAMPLE_WIDTH-1:0];
    clip   = 1'b0;
    if (q > hi) begin
      result = hi[SAMPLE_WIDTH-1:0];
      clip   = 1'b1;
    end else if (q < lo) begin
      result = lo[SAMPLE_WIDTH-1:0];
      clip   = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sfc_checker.sv @@
`default_nettype none
`include "streaming_fir_convolver_macros.svh"
module sfc_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 18
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic [1:0] s_tuser,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  input wire logic m_tlast
);

  // A result waiting on a stalled output must not change.
  `SFC_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output item changed")

  // After reset no result is shown and the input is open.
  `SFC_ASSERT_ALWAYS(a_reset_state, clk, rst |=> !m_tvalid && s_tready, "bad state after reset")

  // A sample item keeps the block busy while its product sum is built.
  `SFC_ASSERT(a_sample_busy, clk, rst, s_tvalid && s_tready && s_tuser == sfc_pkg::CMD_SAMPLE |=> !s_tready, "input open during sample computation")

endmodule

bind streaming_fir_convolver sfc_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .COEF_WIDTH  (COEF_WIDTH)
) u_sfc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
`default_nettype wire

@@ verif/tb_streaming_fir_convolver.sv @@
`default_nettype none
module tb_streaming_fir_convolver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W   = 40;
  localparam int TAPS     = 64;
  localparam int SLOW_RES = TAPS * 18 + 2;
  localparam int WD_LIMIT = 40000;

  typedef struct packed {
    logic [15:0] sample;
    logic        clip;
    logic        last;
  } fir_out_t;

  typedef struct {
    sfc_pkg::cmd_t cmd;
    logic [5:0]    idx;
    logic [17:0]   coef;
    logic [15:0]   smp;
    bit            typed;
    fir_out_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = sfc_pkg::CMD_NONE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sfc_pkg::NUM_TAPS_WIDTH-1:0] cfg_data = '0;

  streaming_fir_convolver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Filter state mirrored by the testbench.
  logic signed [17:0] coef_mem [TAPS];
  logic signed [15:0] taps_line [TAPS];
  int unsigned taps_used = 1;
  fir_out_t filtered_q [$];
  int errors = 0;
  int rx_stall = 0;
  int idle_max = 6;
  int quiet = 0;

  function automatic fir_out_t filter_sum(bit is_last);
    fir_out_t r;
    longint acc;
    longint q;
    acc = 0;
    for (int k = 0; k < taps_used; k++) acc += longint'(coef_mem[k]) * longint'(taps_line[k]);
    acc += longint'(1) << 16;
    q = acc >>> 17;
    r.clip = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.clip = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      r.clip = 1'b1;
    end
    r.sample = q[15:0];
    r.last = is_last;
    return r;
  endfunction

  function automatic void push_sample(logic signed [15:0] x);
    for (int k = TAPS - 1; k > 0; k--) taps_line[k] = taps_line[k-1];
    taps_line[0] = x;
  endfunction

  // Advances the mirrored filter for one accepted item and queues its outputs.
  function automatic void filter_step(sfc_pkg::cmd_t c, logic [5:0] idx, logic [17:0] cv,
                                      logic [15:0] sv, bit use_pred);
    case (c)
      sfc_pkg::CMD_LOAD: begin
        coef_mem[idx] = cv;
      end
      sfc_pkg::CMD_SAMPLE: begin
        push_sample(sv);
        if (use_pred) filtered_q.push_back(filter_sum(1'b0));
      end
      sfc_pkg::CMD_FLUSH: begin
        for (int t = taps_used - 1; t > 0; t--) begin
          push_sample('0);
          filtered_q.push_back(filter_sum(t == 1));
        end
        for (int k = 0; k < TAPS; k++) taps_line[k] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(sfc_pkg::cmd_t c, logic [5:0] idx, logic [17:0] cv,
                           logic [15:0] sv, bit use_pred);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {sv, cv, idx};
    do @(posedge clk); while (!s_tready);
    filter_step(c, idx, cv, sv, use_pred);
  endtask

  task automatic write_taps(logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    taps_used = (v == 0) ? 1 : (v > TAPS) ? TAPS : v;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SLOW_RES + 10) @(posedge clk);
  endtask

  function automatic logic [17:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 18'h1FFFF;
      1: return 18'h20000;
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Output side: compare every accepted result and draw the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h/%b/%b",
                   $realtime, m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          fir_out_t w;
          w = filtered_q.pop_front();
          if (m_tdata !== w.sample || m_tuser !== w.clip || m_tlast !== w.last) begin
            $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $realtime,
                     w.sample, w.clip, w.last, m_tdata, m_tuser, m_tlast);
            errors++;
          end
        end
        rx_stall = $urandom_range(0, idle_max);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      m_tready <= (rx_stall == 0);
    end
  end

  // Watchdog on cycles with no item moving on any channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  stim_row_t rows [$];
  int unsigned phase_taps [10] = '{2, 0, 127, 3, 64, 7, 1, 16, 5, 33};

  initial begin
    int count;
    int r;
    for (int k = 0; k < TAPS; k++) begin
      coef_mem[k] = '0;
      taps_line[k] = '0;
    end
    // With one tap the output is coefficient zero times the newest sample, scaled and saturated.
    rows = '{
      '{sfc_pkg::CMD_LOAD,   6'd0,  18'h20000, 16'h0,    1'b0, '0},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'h8000, 1'b1, '{16'h7FFF, 1'b1, 1'b0}},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'h7FFF, 1'b0, '0},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'h0,    1'b1, '{16'h0, 1'b0, 1'b0}},
      '{sfc_pkg::CMD_FLUSH,  6'd0,  18'h0,     16'h0,    1'b0, '0},
      '{sfc_pkg::CMD_NONE,   6'd63, 18'h3FFFF, 16'hFFFF, 1'b0, '0},
      '{sfc_pkg::CMD_LOAD,   6'd0,  18'h1FFFF, 16'h0,    1'b0, '0},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'h8000, 1'b0, '0},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'h7FFF, 1'b0, '0},
      '{sfc_pkg::CMD_LOAD,   6'd63, 18'h1FFFF, 16'h0,    1'b0, '0},
      '{sfc_pkg::CMD_LOAD,   6'd63, 18'h20000, 16'h0,    1'b0, '0},
      '{sfc_pkg::CMD_LOAD,   6'd0,  18'h0,     16'h0,    1'b0, '0},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'h3039, 1'b1, '{16'h0, 1'b0, 1'b0}},
      '{sfc_pkg::CMD_LOAD,   6'd0,  18'h10000, 16'h0,    1'b0, '0},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'h0002, 1'b1, '{16'h1, 1'b0, 1'b0}},
      '{sfc_pkg::CMD_SAMPLE, 6'd0,  18'h0,     16'hFFFF, 1'b0, '0},
      '{sfc_pkg::CMD_FLUSH,  6'd0,  18'h0,     16'h0,    1'b0, '0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_item(rows[i].cmd, rows[i].idx, rows[i].coef, rows[i].smp, !rows[i].typed);
      if (rows[i].typed) filtered_q.push_back(rows[i].want);
    end
    drain();

    // Every slot gets a value so that any tap count reads written coefficients.
    for (int k = 0; k < TAPS; k++) send_item(sfc_pkg::CMD_LOAD, k[5:0], pick_coef(), '0, 1'b1);

    foreach (phase_taps[p]) begin
      drain();
      write_taps(7'(phase_taps[p]));
      idle_max = (p % 3 == 2) ? 0 : 6;
      count = (taps_used <= 8) ? 18 : 8;
      for (int i = 0; i < count; i++) begin
        if (i == count / 2) drain();
        r = $urandom_range(0, 99);
        if (r < 72)
          send_item(sfc_pkg::CMD_SAMPLE, 6'($urandom), 18'($urandom), pick_sample(), 1'b1);
        else if (r < 82 && (taps_used <= 16 || i == count - 1))
          send_item(sfc_pkg::CMD_FLUSH, 6'($urandom), 18'($urandom), 16'($urandom), 1'b1);
        else if (r < 95)
          send_item(sfc_pkg::CMD_LOAD, 6'($urandom), pick_coef(), 16'($urandom), 1'b1);
        else
          send_item(sfc_pkg::CMD_NONE, 6'($urandom), 18'($urandom), 16'($urandom), 1'b1);
      end
    end
    drain();

    if (errors == 0 && filtered_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/sfc_pkg.sv
rtl/core/sfc_store.sv
rtl/core/sfc_mac.sv
rtl/core/streaming_fir_convolver.sv
rtl/core/sfc_checker.sv
verif/tb_streaming_fir_convolver.sv
